// ===== design/trilinear_volume_sampler_defines.svh =====
// assertion macros for the trilinear volume sampler
// used by the top level only; define NO_ASSERTIONS to drop them
`ifndef TRILINEAR_VOLUME_SAMPLER_DEFINES_SVH
`define TRILINEAR_VOLUME_SAMPLER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TVS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TVS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define TVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/tvs_pkg.sv =====
// shared constants and types for the trilinear volume sampler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tvs_pkg;
  localparam int VolumeWordsDef  = 65536;
  localparam int FractionBitsDef = 8;
  localparam int CoordW  = 18;
  localparam int DimW    = 9;
  localparam int VoxW    = 16;
  localparam int IdxW    = 16;
  localparam int OutW    = 24;
  localparam int CfgIdxW = 2;
  localparam int NumBanks = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DIM_X = 2'd0,
    REG_DIM_Y = 2'd1,
    REG_DIM_Z = 2'd2
  } cfg_reg_t;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;
endpackage
`default_nettype wire

// ===== design/tvs_ram.sv =====
// generic single-port-write, one-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module tvs_ram #(
  parameter int Width = 16,
  parameter int Depth = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/trilinear_volume_sampler.sv =====
// top level of the trilinear volume sampler: replicated volume and blend pipeline
// depends on tvs_pkg, tvs_ram and trilinear_volume_sampler_defines.svh
//
//   channel  | ports                                      | handshake
//   input    | in_func, in_voxel_index, in_voxel_value,   | start & !busy
//            | in_coord_x/y/z                             |
//   result   | out_sample_value                           | out_valid, one cycle
//   config   | cfg_we, cfg_index, cfg_data                | cfg_we
//
// one beat per cycle; a sample result goes through the s-stage registers and the output register
// the volume is held in eight copies, one per neighbour, so all eight are read in the same
// cycle; writes reach the copies at the read stage, so reads see writes in beat order
// busy is never raised; results cannot be held off and the pipe never stalls
// reset clears valid bits and sets the dimensions to one only; the volume is undefined
`timescale 1ns / 1ps
`default_nettype none
`include "trilinear_volume_sampler_defines.svh"
module trilinear_volume_sampler #(
  parameter int VOLUME_WORDS  = tvs_pkg::VolumeWordsDef,
  parameter int FRACTION_BITS = tvs_pkg::FractionBitsDef
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_func,
  input  wire logic [tvs_pkg::IdxW-1:0]          in_voxel_index,
  input  wire logic signed [tvs_pkg::VoxW-1:0]   in_voxel_value,
  input  wire logic signed [tvs_pkg::CoordW-1:0] in_coord_x,
  input  wire logic signed [tvs_pkg::CoordW-1:0] in_coord_y,
  input  wire logic signed [tvs_pkg::CoordW-1:0] in_coord_z,
  output logic                                   out_valid,
  output logic signed [tvs_pkg::OutW-1:0]        out_sample_value,
  input  wire logic                              cfg_we,
  input  wire logic [tvs_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire logic [tvs_pkg::DimW-1:0]          cfg_data
);
  localparam int AW    = $clog2(VOLUME_WORDS);
  localparam int FB    = FRACTION_BITS;
  localparam int DW    = tvs_pkg::DimW;
  localparam int VW    = tvs_pkg::VoxW;
  localparam int BW    = tvs_pkg::CoordW - FB + 1;   // floored base, signed
  localparam int NW    = (BW > DW) ? BW + 1 : DW + 1; // neighbour coordinate, signed
  localparam int WW    = FB + 1;                     // weight 0..2^FB
  localparam int WXW   = 2 * WW;                     // x weight times y weight
  localparam int LinW  = 28;                         // linear address up to 511^3
  localparam int P2W   = VW + WXW + 1;               // voxel * wx * wy
  localparam int P3W   = P2W + WW + 1;
  localparam int SumW  = P3W + 3;
  localparam int OW    = tvs_pkg::OutW;

  assign busy = 1'b0;

  // configuration registers
  logic [DW-1:0] dim_x_r, dim_y_r, dim_z_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_x_r <= DW'(1);
      dim_y_r <= DW'(1);
      dim_z_r <= DW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        tvs_pkg::REG_DIM_X: dim_x_r <= cfg_data;
        tvs_pkg::REG_DIM_Y: dim_y_r <= cfg_data;
        tvs_pkg::REG_DIM_Z: dim_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  wire acc = start & ~busy;
  wire wr_go = acc && (in_func == tvs_pkg::FUNC_WRITE) &&
               ({{(32-tvs_pkg::IdxW){1'b0}}, in_voxel_index} < 32'(VOLUME_WORDS));

  // s1: floor and fractions; write beats ride along
  logic                 s1_v_r, s1_wv_r;
  logic [AW-1:0]        s1_wa_r;
  logic [VW-1:0]        s1_wd_r;
  logic signed [BW-1:0] s1_bx_r, s1_by_r, s1_bz_r;
  logic [FB-1:0]        s1_fx_r, s1_fy_r, s1_fz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s1_wv_r <= 1'b0;
    end else begin
      s1_v_r  <= acc && (in_func == tvs_pkg::FUNC_SAMPLE);
      s1_wv_r <= wr_go;
    end
    s1_wa_r <= AW'(in_voxel_index);
    s1_wd_r <= in_voxel_value;
    s1_bx_r <= BW'(in_coord_x >>> FB);
    s1_by_r <= BW'(in_coord_y >>> FB);
    s1_bz_r <= BW'(in_coord_z >>> FB);
    s1_fx_r <= in_coord_x[FB-1:0];
    s1_fy_r <= in_coord_y[FB-1:0];
    s1_fz_r <= in_coord_z[FB-1:0];
  end

  // s2: per-axis bounds and the y/z part of the linear address
  logic [1:0]      okx_nxt, oky_nxt, okz_nxt;
  logic [DW-1:0]   cx_nxt [2];
  logic [DW-1:0]   cy_nxt [2];
  logic [DW-1:0]   cz_nxt [2];
  logic [LinW-1:0] yz_nxt [4];
  always_comb begin
    for (int d = 0; d < 2; d++) begin
      logic signed [NW-1:0] nx, ny, nz;
      nx = NW'(s1_bx_r) + NW'(d);
      ny = NW'(s1_by_r) + NW'(d);
      nz = NW'(s1_bz_r) + NW'(d);
      okx_nxt[d] = !nx[NW-1] && (nx < $signed(NW'(dim_x_r)));
      oky_nxt[d] = !ny[NW-1] && (ny < $signed(NW'(dim_y_r)));
      okz_nxt[d] = !nz[NW-1] && (nz < $signed(NW'(dim_z_r)));
      cx_nxt[d]  = nx[DW-1:0];
      cy_nxt[d]  = ny[DW-1:0];
      cz_nxt[d]  = nz[DW-1:0];
    end
    for (int j = 0; j < 4; j++)
      yz_nxt[j] = LinW'(cy_nxt[j & 1]) + LinW'(dim_y_r) * LinW'(cz_nxt[j >> 1]);
  end

  logic            s2_v_r, s2_wv_r;
  logic [AW-1:0]   s2_wa_r;
  logic [VW-1:0]   s2_wd_r;
  logic [1:0]      s2_okx_r, s2_oky_r, s2_okz_r;
  logic [DW-1:0]   s2_cx_r [2];
  logic [LinW-1:0] s2_yz_r [4];
  logic [FB-1:0]   s2_fx_r, s2_fy_r, s2_fz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s2_wv_r <= 1'b0;
    end else begin
      s2_v_r  <= s1_v_r;
      s2_wv_r <= s1_wv_r;
    end
    s2_wa_r  <= s1_wa_r;
    s2_wd_r  <= s1_wd_r;
    s2_okx_r <= okx_nxt;
    s2_oky_r <= oky_nxt;
    s2_okz_r <= okz_nxt;
    for (int d = 0; d < 2; d++) s2_cx_r[d] <= cx_nxt[d];
    for (int j = 0; j < 4; j++) s2_yz_r[j] <= yz_nxt[j];
    s2_fx_r  <= s1_fx_r;
    s2_fy_r  <= s1_fy_r;
    s2_fz_r  <= s1_fz_r;
  end

  // s3: linear address per neighbour; a neighbour out of bounds or past the memory is marked not ok
  logic [7:0]    ok3_nxt;
  logic [AW-1:0] addr_nxt [8];
  always_comb begin
    for (int n = 0; n < 8; n++) begin
      logic [LinW-1:0] lin;
      lin = LinW'(s2_cx_r[n & 1]) + LinW'(dim_x_r) * s2_yz_r[n >> 1];
      ok3_nxt[n] = s2_okx_r[n & 1] && s2_oky_r[(n >> 1) & 1] && s2_okz_r[n >> 2] &&
                   (lin < LinW'(VOLUME_WORDS));
      addr_nxt[n] = lin[AW-1:0];
    end
  end

  logic          s3_v_r, s3_wv_r;
  logic [AW-1:0] s3_wa_r;
  logic [VW-1:0] s3_wd_r;
  logic [7:0]    s3_ok_r;
  logic [AW-1:0] s3_addr_r [8];
  logic [FB-1:0] s3_fx_r, s3_fy_r, s3_fz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r  <= 1'b0;
      s3_wv_r <= 1'b0;
    end else begin
      s3_v_r  <= s2_v_r;
      s3_wv_r <= s2_wv_r;
    end
    s3_wa_r <= s2_wa_r;
    s3_wd_r <= s2_wd_r;
    s3_ok_r <= ok3_nxt;
    for (int n = 0; n < 8; n++) s3_addr_r[n] <= addr_nxt[n];
    s3_fx_r <= s2_fx_r;
    s3_fy_r <= s2_fy_r;
    s3_fz_r <= s2_fz_r;
  end

  // volume copies: every write goes to all, copy n serves neighbour n
  logic [VW-1:0] copy_rd [8];
  for (genvar b = 0; b < 8; b++) begin : g_copy
    tvs_ram #(.Width(VW), .Depth(VOLUME_WORDS)) u_ram (
      .clk   (clk),
      .we    (s3_wv_r),
      .waddr (s3_wa_r),
      .wdata (s3_wd_r),
      .raddr (s3_addr_r[b]),
      .rdata (copy_rd[b])
    );
  end

  // s4: read data arrives; x and y weight products
  logic            s4_v_r;
  logic [7:0]      s4_ok_r;
  logic [WXW-1:0]  s4_wxy_r [4];
  logic [FB-1:0]   s4_fz_r;
  always_ff @(posedge clk) begin
    logic [WW-1:0] wx, wy;
    if (!rst_n) s4_v_r <= 1'b0;
    else        s4_v_r <= s3_v_r;
    for (int j = 0; j < 4; j++) begin
      wx = (j & 1) != 0 ? WW'(s3_fx_r) : WW'(1 << FB) - WW'(s3_fx_r);
      wy = (j & 2) != 0 ? WW'(s3_fy_r) : WW'(1 << FB) - WW'(s3_fy_r);
      s4_wxy_r[j] <= WXW'(wx) * WXW'(wy);
    end
    s4_ok_r <= s3_ok_r;
    s4_fz_r <= s3_fz_r;
  end

  // s5: voxel times x and y weights
  logic                  s5_v_r;
  logic signed [P2W-1:0] s5_p_r [8];
  logic [FB-1:0]         s5_fz_r;
  always_ff @(posedge clk) begin
    logic signed [VW-1:0] vox;
    if (!rst_n) s5_v_r <= 1'b0;
    else        s5_v_r <= s4_v_r;
    for (int n = 0; n < 8; n++) begin
      vox = s4_ok_r[n] ? $signed(copy_rd[n]) : '0;
      s5_p_r[n] <= P2W'(vox) * P2W'($signed({1'b0, s4_wxy_r[n & 3]}));
    end
    s5_fz_r <= s4_fz_r;
  end

  // s6: times z weight
  logic                  s6_v_r;
  logic signed [P3W-1:0] s6_p_r [8];
  always_ff @(posedge clk) begin
    logic [WW-1:0] wz;
    if (!rst_n) s6_v_r <= 1'b0;
    else        s6_v_r <= s5_v_r;
    for (int n = 0; n < 8; n++) begin
      wz = (n & 4) != 0 ? WW'(s5_fz_r) : WW'(1 << FB) - WW'(s5_fz_r);
      s6_p_r[n] <= P3W'(s5_p_r[n]) * P3W'($signed({1'b0, wz}));
    end
  end

  // s7: sums of four
  logic                   s7_v_r;
  logic signed [SumW-1:0] s7_s_r [2];
  always_ff @(posedge clk) begin
    if (!rst_n) s7_v_r <= 1'b0;
    else        s7_v_r <= s6_v_r;
    for (int h = 0; h < 2; h++)
      s7_s_r[h] <= SumW'(s6_p_r[4*h]) + SumW'(s6_p_r[4*h+1]) +
                   SumW'(s6_p_r[4*h+2]) + SumW'(s6_p_r[4*h+3]);
  end

  // final sum, round half up, saturate
  logic signed [SumW-1:0] tot, rnd;
  always_comb begin
    tot = s7_s_r[0] + s7_s_r[1];
    rnd = (tot + (SumW'(1) <<< (2*FB-1))) >>> (2*FB);
  end
  logic signed [SumW-1:0] sat_max, sat_min;
  assign sat_max = SumW'((1 << (OW-1)) - 1);
  assign sat_min = -(SumW'(1) <<< (OW-1));
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= s7_v_r;
    if (rnd > sat_max)      out_sample_value <= OW'(sat_max);
    else if (rnd < sat_min) out_sample_value <= OW'(sat_min);
    else                    out_sample_value <= OW'(rnd);
  end

  `TVS_ASSERT_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy)
  `TVS_ASSERT_NEXT(a_sample_flows, clk, rst_n, s1_v_r, s2_v_r)
  `TVS_ASSERT_NEXT(a_result_follows, clk, rst_n, s7_v_r, out_valid)
endmodule
`default_nettype wire
